>>> rtl/sle_pkg.sv
package sle_pkg;

   localparam int DEPTH_DEFAULT      = 16;
   localparam int VALUE_BITS_DEFAULT = 32;

   // fixed field widths on the ports
   localparam int OP_BITS     = 2;
   localparam int KEY_BITS    = 32;
   localparam int STATUS_BITS = 2;
   localparam int POS_BITS    = 4;
   localparam int COUNT_BITS  = 5;
   localparam int REQ_DATA_BITS = 32;
   localparam int RSP_DATA_BITS = 16;

   typedef enum logic [OP_BITS-1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_DONE = 2'd0,
      ST_MISS = 2'd1,
      ST_FULL = 2'd2
   } status_type;

   // broadcast from the top level to every cell
   typedef struct packed {
      logic   go;     // request accepted this cycle
      op_type op;
      logic   allow;  // insert with room, or delete that hits
   } cmd_type;

endpackage

>>> rtl/sle_cell.sv
module sle_cell #(
   parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  sle_pkg::cmd_type      cmd,
   input  logic [VALUE_BITS-1:0] key,
   // lower neighbour
   input  logic                  prev_lt,
   input  logic                  prev_valid,
   input  logic [VALUE_BITS-1:0] prev_value,
   // upper neighbour
   input  logic                  next_valid,
   input  logic [VALUE_BITS-1:0] next_value,
   output logic                  valid,
   output logic [VALUE_BITS-1:0] value,
   output logic                  lt,
   output logic                  eq,
   output logic                  at_pos
);

   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;

   assign valid  = valid_ff;
   assign value  = value_ff;
   assign lt     = valid_ff && ($signed(value_ff) < $signed(key));
   assign eq     = valid_ff && (value_ff == key);
   assign at_pos = prev_lt && !lt;   // first cell not below the key

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (cmd.go) begin
         case (cmd.op)
            sle_pkg::OP_INSERT: begin
               if (cmd.allow && !lt) begin
                  if (prev_lt) begin
                     value_in = key;
                     valid_in = 1'b1;
                  end else begin
                     value_in = prev_value;
                     valid_in = prev_valid;
                  end
               end
            end
            sle_pkg::OP_DELETE: begin
               if (cmd.allow && !lt) begin
                  value_in = next_value;
                  valid_in = next_valid;
               end
            end
            sle_pkg::OP_CLEAR: begin
               valid_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

>>> rtl/sorted_list_engine.sv
// Latency: the response is presented in the cycle after the request is accepted.
// Throughput: one request per cycle; every cell compares against the key in
//   parallel and takes its new value from itself, the key or a neighbour.
// A stalled response holds req_tready low until it is taken.
// Reset (synchronous, active high) empties the table and drops any pending
// response; stored values are left as they are and never read while invalid.
module sorted_list_engine #(
   parameter int DEPTH      = sle_pkg::DEPTH_DEFAULT,
   parameter int VALUE_BITS = sle_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [sle_pkg::REQ_DATA_BITS-1:0] req_tdata,  // [31:0] value
   input  logic [sle_pkg::OP_BITS-1:0]       req_tuser,  // [1:0] operation
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [sle_pkg::RSP_DATA_BITS-1:0] rsp_tdata,  // [3:0] position, [8:4] entry_count
   output logic [sle_pkg::STATUS_BITS-1:0]   rsp_tuser   // [1:0] status
);

   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic                  accept;
   logic [VALUE_BITS-1:0] key;
   sle_pkg::op_type       op;
   sle_pkg::cmd_type      cmd;

   // cell row, with one extra link below cell 0
   logic                  lt_link    [DEPTH+1];
   logic                  valid_link [DEPTH+1];
   logic [VALUE_BITS-1:0] value_link [DEPTH+1];
   logic [DEPTH-1:0]      eq_vec;
   logic [DEPTH-1:0]      pos_vec;
   logic [DEPTH-1:0]      valid_vec;

   logic                  full;
   logic                  hit;
   logic [sle_pkg::POS_BITS-1:0] pos_enc;

   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   sle_pkg::status_type   status_ff, status_in;
   logic [sle_pkg::POS_BITS-1:0]   position_ff, position_in;
   logic [sle_pkg::COUNT_BITS-1:0] entries_ff, entries_in;

   // a new request enters whenever the response slot is empty or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign key        = VALUE_BITS'(req_tdata[sle_pkg::KEY_BITS-1:0]);
   assign op         = sle_pkg::op_type'(req_tuser);

   assign full = (count_ff == CNT_BITS'(DEPTH));

   // cell 0 sees "everything below me is smaller"; the top cell sees an empty neighbour
   assign lt_link[0]        = 1'b1;
   assign valid_link[0]     = 1'b1;
   assign value_link[0]     = '0;

   logic                  top_valid;
   logic [VALUE_BITS-1:0] top_value;
   assign top_valid = 1'b0;
   assign top_value = '0;

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic                  nxt_valid;
         logic [VALUE_BITS-1:0] nxt_value;
         if (g == DEPTH - 1) begin : g_top
            assign nxt_valid = top_valid;
            assign nxt_value = top_value;
         end else begin : g_mid
            assign nxt_valid = valid_link[g+2];
            assign nxt_value = value_link[g+2];
         end
         sle_cell #(
            .VALUE_BITS(VALUE_BITS)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .key        (key),
            .prev_lt    (lt_link[g]),
            .prev_valid (valid_link[g]),
            .prev_value (value_link[g]),
            .next_valid (nxt_valid),
            .next_value (nxt_value),
            .valid      (valid_link[g+1]),
            .value      (value_link[g+1]),
            .lt         (lt_link[g+1]),
            .eq         (eq_vec[g]),
            .at_pos     (pos_vec[g])
         );
         assign valid_vec[g] = valid_link[g+1];
      end
   endgenerate

   // at most one cell sits at the insertion point (exactly one while a cell is free); the first match can only be there
   always_comb begin
      hit     = 1'b0;
      pos_enc = '0;
      for (int i = 0; i < DEPTH; i++) begin
         hit     = hit | (pos_vec[i] & eq_vec[i]);
         pos_enc = pos_enc | (pos_vec[i] ? sle_pkg::POS_BITS'(i) : '0);
      end
   end

   always_comb begin
      cmd.go    = accept;
      cmd.op    = op;
      cmd.allow = 1'b0;
      case (op)
         sle_pkg::OP_INSERT: cmd.allow = !full;
         sle_pkg::OP_DELETE: cmd.allow = hit;
         default:            cmd.allow = 1'b0;
      endcase
   end

   // next table size and the response fields
   always_comb begin
      count_in    = count_ff;
      status_in   = status_ff;
      position_in = position_ff;
      entries_in  = entries_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept) begin
         rsp_valid_in = 1'b1;
         status_in    = sle_pkg::ST_DONE;
         position_in  = pos_enc;
         case (op)
            sle_pkg::OP_INSERT: begin
               if (full) begin
                  status_in   = sle_pkg::ST_FULL;
                  position_in = '0;
               end else begin
                  count_in = count_ff + CNT_BITS'(1);
               end
            end
            sle_pkg::OP_DELETE: begin
               if (hit) begin
                  count_in = count_ff - CNT_BITS'(1);
               end else begin
                  status_in   = sle_pkg::ST_MISS;
                  position_in = '0;
               end
            end
            sle_pkg::OP_SEARCH: begin
               if (!hit) begin
                  status_in   = sle_pkg::ST_MISS;
                  position_in = '0;
               end
            end
            sle_pkg::OP_CLEAR: begin
               count_in    = '0;
               position_in = '0;
            end
            default: begin
            end
         endcase
         entries_in = sle_pkg::COUNT_BITS'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff   <= status_in;
      position_ff <= position_in;
      entries_ff  <= entries_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = {{(sle_pkg::RSP_DATA_BITS - sle_pkg::POS_BITS - sle_pkg::COUNT_BITS){1'b0}},
                        entries_ff, position_ff};

   // the count never runs past the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH))
      else $error("entry count beyond table depth");

   // valid cells and the count agree
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(count_ff))
      else $error("valid cells disagree with entry count");

   // insertion point is unique while there is a free cell
   a_one_pos: assert property (@(posedge clock) disable iff (reset)
      !full |-> $onehot(pos_vec))
      else $error("insertion point not unique");

   // a clear empties the table
   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && op == sle_pkg::OP_CLEAR |=> count_ff == '0 && valid_vec == '0)
      else $error("clear left entries behind");

   // a full table drops the insert and leaves the count alone
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      accept && op == sle_pkg::OP_INSERT && full |=> $stable(count_ff) && position_ff == '0)
      else $error("insert into full table changed the table");

endmodule
